// ===== hw/rtl/tmh_pkg.sv =====
// shared types and constants of the ternary max-heap
`default_nettype none

package tmh_pkg;

   // default number of heap entries
   localparam int CAPACITY_DEFAULT = 64;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // request beat
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   // response beat
   typedef struct packed {
      logic signed [31:0] max_value;
      logic               empty_res;
      logic               overflow;
      logic [6:0]         entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ternary_max_heap.sv =====
// top level of the ternary max-heap: command sequencer, store and compare unit
`default_nettype none

// Fixed-capacity 3-ary max-heap of signed 32-bit values. A command is taken
// when start is high and busy is low; its single response beat appears on
// rsp_data with rsp_strobe high for one cycle and cannot be held off. A
// query, an insert into a full heap and a delete on an empty heap go to
// the finishing step at once. An insert reads and compares the parent at
// each level until the value reaches the root or is not above its parent.
// A delete loads the last entry, then at each level reads the children one
// by one (at most three), keeps the largest and compares it with the moving
// value, over about log3 of the fill count levels; a value that comes to
// rest on a leaf is written when the child check finds no child. These
// steps follow from the single read port of the entry memory, which reads
// one child or parent per cycle into a registered output, and from the one
// shared compare unit. Sifts move a hole and write the moving value once at
// its final place. No clearing pass is needed.
module ternary_max_heap #(
   parameter int CAPACITY = tmh_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tmh_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output tmh_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = IW + 2;
   // reciprocal of three for the parent index
   localparam int S  = IW + 2;
   localparam logic [S-1:0] RECIP3 = S'((2 ** S) / 3 + 1);
   localparam logic [1:0] LAST_KID = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_CHK,
      ST_DN_KID,
      ST_DN_DEC,
      ST_FIN
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    fill_ff;
   logic [IW-1:0]    pos_ff;
   logic [31:0]      cur_ff;
   logic [31:0]      best_val_ff;
   logic [IW-1:0]    best_idx_ff;
   logic [KW-1:0]    kid_ff;
   logic [1:0]       kcnt_ff;
   logic [31:0]      root_ff;
   logic             ovf_ff;
   logic             strobe_ff;
   tmh_pkg::rsp_type rsp_ff;

   // memory and compare hookup
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [31:0]   rd_data_ff;
   logic [31:0]   op_a;
   logic [31:0]   op_b;
   logic          a_gt_b;

   // index arithmetic
   logic [KW-1:0]    fill_ext;
   logic [KW-1:0]    first_kid;
   logic [KW-1:0]    next_kid;
   logic             kid_room;
   logic [IW+S-1:0]  parent_prod;
   logic [IW-1:0]    parent_idx;
   logic [CW-1:0]    last_idx;
   logic             full;
   logic             take_kid;
   logic [CW+6:0]    count_ext;

   tmh_store #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   tmh_cmp u_cmp (
      .op_a   (op_a),
      .op_b   (op_b),
      .a_gt_b (a_gt_b)
   );

   // child and parent indexes
   assign fill_ext    = KW'(fill_ff);
   assign first_kid   = (KW'(pos_ff) << 1) + KW'(pos_ff) + KW'(1);
   assign next_kid    = kid_ff + KW'(1);
   assign kid_room    = (kcnt_ff != LAST_KID) && (next_kid < fill_ext);
   assign parent_prod = (IW+S)'(pos_ff - IW'(1)) * (IW+S)'(RECIP3);
   assign parent_idx  = parent_prod[IW+S-1:S];
   assign last_idx    = fill_ff - CW'(1);
   assign full        = (fill_ff == CW'(CAPACITY));
   assign take_kid    = (kcnt_ff == 2'd0) || a_gt_b;
   assign count_ext   = (CW+7)'(fill_ff);

   // memory ports and compare operands per step
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      rd_en   = 1'b0;
      rd_addr = pos_ff;
      op_a    = cur_ff;
      op_b    = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = last_idx[IW-1:0];
            rd_en   = start && (req_data.cmd == tmh_pkg::CMD_DELETE) && (fill_ff != '0);
         end
         ST_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = parent_idx;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (a_gt_b) begin
               wr_data = rd_data_ff;
            end
         end
         ST_DN_CHK: begin
            if (first_kid >= fill_ext) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = first_kid[IW-1:0];
            end
         end
         ST_DN_KID: begin
            op_a    = rd_data_ff;
            op_b    = best_val_ff;
            rd_en   = kid_room;
            rd_addr = next_kid[IW-1:0];
         end
         ST_DN_DEC: begin
            op_a  = best_val_ff;
            op_b  = cur_ff;
            wr_en = 1'b1;
            if (a_gt_b) begin
               wr_data = best_val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // root copy follows every write of entry zero
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= wr_data;
      end
   end

   // command sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  ovf_ff <= 1'b0;
                  unique case (req_data.cmd)
                     tmh_pkg::CMD_INSERT: begin
                        if (full) begin
                           ovf_ff   <= 1'b1;
                           state_ff <= ST_FIN;
                        end else begin
                           cur_ff   <= req_data.value;
                           pos_ff   <= fill_ff[IW-1:0];
                           fill_ff  <= fill_ff + CW'(1);
                           state_ff <= ST_UP_CHK;
                        end
                     end
                     tmh_pkg::CMD_DELETE: begin
                        if (fill_ff != '0) begin
                           fill_ff  <= last_idx;
                           state_ff <= ST_DN_LOAD;
                        end else begin
                           state_ff <= ST_FIN;
                        end
                     end
                     default: begin
                        state_ff <= ST_FIN;
                     end
                  endcase
               end
            end
            ST_UP_CHK: begin
               state_ff <= (pos_ff == '0) ? ST_FIN : ST_UP_CMP;
            end
            ST_UP_CMP: begin
               if (a_gt_b) begin
                  pos_ff   <= parent_idx;
                  state_ff <= ST_UP_CHK;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_DN_LOAD: begin
               cur_ff   <= rd_data_ff;
               pos_ff   <= '0;
               state_ff <= ST_DN_CHK;
            end
            ST_DN_CHK: begin
               if (first_kid >= fill_ext) begin
                  state_ff <= ST_FIN;
               end else begin
                  kid_ff   <= first_kid;
                  kcnt_ff  <= 2'd0;
                  state_ff <= ST_DN_KID;
               end
            end
            ST_DN_KID: begin
               // first child on ties
               if (take_kid) begin
                  best_val_ff <= rd_data_ff;
                  best_idx_ff <= kid_ff[IW-1:0];
               end
               if (kid_room) begin
                  kid_ff  <= next_kid;
                  kcnt_ff <= kcnt_ff + 2'd1;
               end else begin
                  state_ff <= ST_DN_DEC;
               end
            end
            ST_DN_DEC: begin
               if (a_gt_b) begin
                  pos_ff   <= best_idx_ff;
                  state_ff <= ST_DN_CHK;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               rsp_ff.max_value   <= (fill_ff != '0) ? root_ff : 32'sd0;
               rsp_ff.empty_res   <= (fill_ff == '0);
               rsp_ff.overflow    <= ovf_ff;
               rsp_ff.entry_count <= count_ext[6:0];
               strobe_ff          <= 1'b1;
               state_ff           <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // fill count stays within capacity
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   // every finished command gives one response beat
   a_fin_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> rsp_strobe)
      else $error("finished command without response");

   // an accepted command makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted but block not busy");

   // a response beat only shows while idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response beat while busy");

   // a dropped insert leaves a full heap
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.overflow) |-> full)
      else $error("overflow reported on a heap that is not full");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tmh_cmp.sv =====
// shared signed compare unit used by every compare step of both sifts
`default_nettype none

module tmh_cmp (
   input  wire logic signed [31:0] op_a,
   input  wire logic signed [31:0] op_b,
   output logic                    a_gt_b
);

   // strict signed greater-than
   assign a_gt_b = (op_a > op_b);

endmodule

`default_nettype wire

// ===== hw/rtl/tmh_store.sv =====
// heap entry memory: one write port, one read port with registered data
`default_nettype none

module tmh_store #(
   parameter int DEPTH = tmh_pkg::CAPACITY_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [31:0]       rd_data_ff
);

   logic [31:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== bench/tmh_checker.sv =====
// scoreboard for the ternary max-heap: tracks the heap contents and checks every response beat
`timescale 1ns / 1ps

module tmh_checker #(
   parameter int CAPACITY = tmh_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire tmh_pkg::req_type req_data,
   input  wire logic             rsp_strobe,
   input  wire tmh_pkg::rsp_type rsp_data,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    checked_count,
   output int                    overflow_count,
   output int                    idle_delete_count,
   output int                    peak_fill
);

   // mirror of the heap array and its fill level
   logic signed [31:0] model_entries [CAPACITY];
   int                 model_fill = 0;

   // responses owed by the block, oldest first
   tmh_pkg::rsp_type   owed_reports [$];

   int fails = 0;
   int checked = 0;
   int overflows = 0;
   int idle_deletes = 0;
   int peak = 0;

   // apply one command to the mirror and return the response it must produce
   function automatic tmh_pkg::rsp_type heap_command(input tmh_pkg::req_type beat);
      tmh_pkg::rsp_type   rep;
      int                 pos;
      int                 up;
      int                 first;
      int                 best;
      int                 k;
      logic signed [31:0] tmp;
      rep = '0;
      case (beat.cmd)
         tmh_pkg::CMD_INSERT: begin
            if (model_fill >= CAPACITY) begin
               rep.overflow = 1'b1;
               overflows++;
            end else begin
               model_entries[model_fill] = beat.value;
               model_fill++;
               // climb while the parent is strictly smaller
               pos = model_fill - 1;
               while (pos > 0) begin
                  up = (pos - 1) / 3;
                  if (model_entries[pos] <= model_entries[up])
                     break;
                  tmp = model_entries[pos];
                  model_entries[pos] = model_entries[up];
                  model_entries[up] = tmp;
                  pos = up;
               end
            end
         end
         tmh_pkg::CMD_DELETE: begin
            if (model_fill == 0) begin
               idle_deletes++;
            end else begin
               model_entries[0] = model_entries[model_fill - 1];
               model_fill--;
               // sink toward the largest child, first one wins a tie
               pos = 0;
               while (3 * pos + 1 < model_fill) begin
                  first = 3 * pos + 1;
                  best = first;
                  for (k = first + 1; k <= first + 2 && k < model_fill; k++) begin
                     if (model_entries[k] > model_entries[best])
                        best = k;
                  end
                  if (model_entries[best] <= model_entries[pos])
                     break;
                  tmp = model_entries[best];
                  model_entries[best] = model_entries[pos];
                  model_entries[pos] = tmp;
                  pos = best;
               end
            end
         end
         // query and the spare code leave the heap alone
         default: ;
      endcase
      if (model_fill > 0)
         rep.max_value = model_entries[0];
      rep.empty_res = (model_fill == 0);
      rep.entry_count = 7'(model_fill);
      return rep;
   endfunction

   // compare response beats, then log the command taken at this edge
   always @(posedge clock) begin : watch
      tmh_pkg::rsp_type want;
      if (reset) begin
         model_fill = 0;
         owed_reports.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (owed_reports.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display({"%0t: response beat with none outstanding: ",
                            "max=%0d empty=%0b ovf=%0b count=%0d"},
                           $time, rsp_data.max_value, rsp_data.empty_res,
                           rsp_data.overflow, rsp_data.entry_count);
            end else begin
               want = owed_reports.pop_front();
               checked++;
               if (rsp_data !== want) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: mismatch: expected max=%0d empty=%0b ovf=%0b count=%0d,",
                               " got max=%0d empty=%0b ovf=%0b count=%0d"},
                              $time, want.max_value, want.empty_res, want.overflow,
                              want.entry_count, rsp_data.max_value, rsp_data.empty_res,
                              rsp_data.overflow, rsp_data.entry_count);
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            fails++;
            if (fails <= 10)
               $display("%0t: response strobe is unknown", $time);
         end
         if (start === 1'b1 && busy === 1'b0)
            owed_reports.insert(owed_reports.size(), heap_command(req_data));
         if (model_fill > peak)
            peak = model_fill;
      end
      mismatch_count <= fails;
      pending_count <= owed_reports.size();
      checked_count <= checked;
      overflow_count <= overflows;
      idle_delete_count <= idle_deletes;
      peak_fill <= peak;
   end

endmodule

// ===== bench/tb_ternary_max_heap.sv =====
// top of the ternary max-heap bench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb_ternary_max_heap;

   localparam int         ITEM_TARGET  = 1350;
   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         DRAIN_CYCLES = 40;
   // unused command code, handled like a query
   localparam logic [1:0] CMD_SPARE    = 2'd3;

   typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   tmh_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   tmh_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int overflow_count;
   int idle_delete_count;
   int peak_fill;

   int issued = 0;
   int inserts = 0;
   int deletes = 0;
   int queries = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ternary_max_heap #(.CAPACITY(tmh_pkg::CAPACITY_DEFAULT)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   tmh_checker #(.CAPACITY(tmh_pkg::CAPACITY_DEFAULT)) scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .overflow_count    (overflow_count),
      .idle_delete_count (idle_delete_count),
      .peak_fill         (peak_fill)
   );

   // value mix: full range, extremes, a narrow band for ties, a moderate band
   function automatic logic signed [31:0] pick_value();
      int unsigned        sel;
      logic signed [31:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         v = $urandom;
      end else if (sel < 40) begin
         case ($urandom_range(0, 6))
            0: v = 32'h7fffffff;
            1: v = 32'h80000000;
            2: v = 32'h80000001;
            3: v = 32'h7ffffffe;
            4: v = 32'hffffffff;
            5: v = 32'h00000001;
            default: v = 32'h00000000;
         endcase
      end else if (sel < 70) begin
         v = $signed($urandom_range(0, 16)) - 8;
      end else begin
         v = $signed($urandom_range(0, 2000)) - 1000;
      end
      return v;
   endfunction

   // command mix per phase kind, with a few spare codes everywhere
   function automatic logic [1:0] draw_cmd(input phase_kind_type kind);
      int unsigned r;
      int unsigned ins_cut;
      int unsigned del_cut;
      r = $urandom_range(0, 99);
      case (kind)
         FILL_PHASE: begin
            ins_cut = 85;
            del_cut = 91;
         end
         DRAIN_PHASE: begin
            ins_cut = 12;
            del_cut = 86;
         end
         default: begin
            ins_cut = 45;
            del_cut = 80;
         end
      endcase
      if (r < 3)
         return CMD_SPARE;
      else if (r < ins_cut)
         return tmh_pkg::CMD_INSERT;
      else if (r < del_cut)
         return tmh_pkg::CMD_DELETE;
      else
         return tmh_pkg::CMD_QUERY;
   endfunction

   // idle cycles before a beat: none, uniform, or mostly back to back
   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 15);
         default: return ($urandom_range(0, 7) == 0) ? 15 : 0;
      endcase
   endfunction

   // drive one command beat and hold it until it is taken
   task automatic issue(input logic [1:0] cmd, input logic signed [31:0] value, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{cmd: cmd, value: value};
      do @(posedge clock); while (busy !== 1'b0);
      issued++;
      case (cmd)
         tmh_pkg::CMD_INSERT: inserts++;
         tmh_pkg::CMD_DELETE: deletes++;
         default:             queries++;
      endcase
   endtask

   initial begin : stimulus
      phase_kind_type kind;
      int             mode;
      int             span;
      int             n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty heap: query, delete with nothing held, spare code
      issue(tmh_pkg::CMD_QUERY, 32'h00000000, draw_gap(1));
      issue(tmh_pkg::CMD_DELETE, 32'h7fffffff, draw_gap(1));
      issue(CMD_SPARE, 32'hffffffff, draw_gap(1));
      // extremes of the value range, both orders of arrival
      issue(tmh_pkg::CMD_INSERT, 32'h80000000, draw_gap(1));
      issue(tmh_pkg::CMD_QUERY, 32'h00000000, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'h7fffffff, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'hffffffff, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'h00000000, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'h00000001, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'h7fffffff, draw_gap(1));
      issue(CMD_SPARE, 32'h00000000, draw_gap(1));
      // drain everything and one more
      for (n = 0; n < 7; n++)
         issue(tmh_pkg::CMD_DELETE, 32'h00000000, draw_gap(1));
      // equal children, then drain
      issue(tmh_pkg::CMD_INSERT, 32'sd5, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'sd5, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'sd5, draw_gap(1));
      issue(tmh_pkg::CMD_INSERT, 32'sd3, draw_gap(1));
      for (n = 0; n < 4; n++)
         issue(tmh_pkg::CMD_DELETE, 32'h00000000, draw_gap(1));

      // run past capacity so full inserts get refused
      for (n = 0; n < 72; n++)
         issue(tmh_pkg::CMD_INSERT, pick_value(), (n % 24 < 12) ? 0 : draw_gap(1));

      // random phases of filling, draining and mixed traffic
      while (issued < ITEM_TARGET) begin
         kind = phase_kind_type'($urandom_range(0, 2));
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 120);
         for (n = 0; n < span && issued < ITEM_TARGET; n++)
            issue(draw_cmd(kind), pick_value(), draw_gap(mode));
      end
      start <= 1'b0;

      // let the last responses come back
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d commands: %0d inserts, %0d deletes, %0d queries",
               issued, inserts, deletes, queries);
      $display("%0d responses checked, %0d refused full inserts, %0d deletes on empty, peak fill %0d",
               checked_count, overflow_count, idle_delete_count, peak_fill);
      if (mismatch_count == 0)
         $display("tb_ternary_max_heap: done, clean");
      else
         $display("tb_ternary_max_heap: done, errors");
      $finish;
   end

   // watchdog on total run length
   initial begin : watchdog
      int unsigned ticks;
      ticks = 0;
      while (ticks < CYCLE_LIMIT) begin
         @(posedge clock);
         ticks++;
      end
      $display("tb_ternary_max_heap: done, errors");
      $finish;
   end

endmodule
